>>> design/wkrf_pkg.sv
// wkrf_pkg: shared constants, codes and payload types of the window keep read filter
// no dependencies; imported by every module of the block
package wkrf_pkg;

   localparam int NUM_WINDOWS = 65536;
   localparam int WIN_BITS    = $clog2(NUM_WINDOWS);
   localparam int WORD_BITS   = 64;
   localparam int BIT_BITS    = $clog2(WORD_BITS);
   localparam int ROWS        = NUM_WINDOWS / WORD_BITS;
   localparam int ROW_BITS    = WIN_BITS - BIT_BITS;
   localparam int LO_BITS     = WIN_BITS + 1;
   localparam int POS_BITS    = 31;
   localparam int CFG_BITS    = 16;
   localparam int ID_BITS     = 32;
   localparam int CSR_IDX_BITS = 1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_SIZE   = 1'b1;

   // request action codes
   localparam logic [1:0] ACT_MARK_PLUS  = 2'd0;
   localparam logic [1:0] ACT_MARK_MINUS = 2'd1;
   localparam logic [1:0] ACT_TEST       = 2'd2;
   localparam logic [1:0] ACT_NONE       = 2'd3;

   typedef enum logic {
      CMD_MARK,
      CMD_TEST
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]          action;
      logic [15:0]         window_index;
      logic                strand;
      logic [POS_BITS-1:0] start_pos;
      logic [POS_BITS-1:0] end_pos;
      logic [ID_BITS-1:0]  read_id;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] read_tag;
      logic               keep;
   } rsp_type;

   // one position, prepared for the two unsigned divisions by the step
   typedef struct packed {
      logic                lo_pos;   // p - window_size is above zero
      logic [POS_BITS-1:0] lo_div;
      logic                p_zero;
      logic [POS_BITS-1:0] hi_div;
   } pos_prep_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  strand;   // map select for marks too
      logic [WIN_BITS-1:0]   window_index;
      logic [ID_BITS-1:0]    read_id;
      pos_prep_type [1:0]    pos;      // 0 start, 1 end
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_port_type;

endpackage

>>> design/window_keep_read_filter.sv
// window_keep_read_filter: top level, csr registers and the front and back halves
// depends on wkrf_pkg, wkrf_front, wkrf_back
//
// keeps one kept-window bitmap per strand (65536 windows each) and tests reads against
// them. a request is taken on a rising edge with start high and busy low. after reset
// the block runs a clearing pass over both maps and holds busy high for it. a mark
// request sets one bit in the back end. a test request computes, for the start
// position and then (only if the start found nothing) the end position, the window
// range through two divisions by step_size on a shared serial divider, then scans
// the strand's map one 64-bit row per cycle. a two-entry request queue lets new
// requests in while the back end works. each test request gives exactly one
// response, shown for one cycle with rsp_strobe high; the receiver cannot stall it
// and must take it then. unused action codes are taken and dropped. the user must
// write window_size and step_size through the csr port only while no request is in
// flight; the block itself does not enforce it. a step_size of zero acts as one
module window_keep_read_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  wkrf_pkg::req_type                 req_data,
   output logic                              busy,
   output logic                              rsp_strobe,
   output wkrf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [wkrf_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [wkrf_pkg::CFG_BITS-1:0]     csr_wdata
);
   import wkrf_pkg::*;

   // configuration registers
   logic [CFG_BITS-1:0] window_size_ff, window_size_in;
   logic [CFG_BITS-1:0] step_size_ff, step_size_in;
   logic [CFG_BITS-1:0] step_eff;

   // queue between the halves
   q_port_type          q_head;
   logic                q_pop;
   logic                clearing;

   always_comb begin
      window_size_in = window_size_ff;
      step_size_in   = step_size_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_WINDOW_SIZE) begin
            window_size_in = csr_wdata;
         end else if (csr_index == CSR_STEP_SIZE) begin
            step_size_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CFG_BITS'(1);
         step_size_ff   <= CFG_BITS'(1);
      end else begin
         window_size_ff <= window_size_in;
         step_size_ff   <= step_size_in;
      end
   end

   // zero step behaves as a step of one
   assign step_eff = (step_size_ff == '0) ? CFG_BITS'(1) : step_size_ff;

   // front: decode the action, subtract the window size, queue the command
   wkrf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .hold        (clearing),
      .window_size (window_size_ff),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   // back: map writes, range division, row scan, response register
   wkrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .step_size  (step_eff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> design/wkrf_front.sv
// wkrf_front: accepts requests, decodes the action, prepares dividends, queues commands
// depends on wkrf_pkg
module wkrf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  wkrf_pkg::req_type             req_data,
   output logic                          busy,
   input  logic                          hold,
   input  logic [wkrf_pkg::CFG_BITS-1:0] window_size,
   output wkrf_pkg::q_port_type          q_head,
   input  logic                          q_pop
);
   import wkrf_pkg::*;

   localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap
   localparam int Q_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   cmd_type                q_mem_ff [QUEUE_DEPTH];
   logic [Q_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]  count_ff, count_in;
   cmd_type                push_cmd;
   logic                   push_ok;
   logic                   push;

   function automatic pos_prep_type prep_pos(input logic [POS_BITS-1:0] p,
                                             input logic [CFG_BITS-1:0] win);
      logic [POS_BITS:0] diff;
      logic [POS_BITS:0] dec;
      logic [POS_BITS:0] neg;
      pos_prep_type      r;
      diff     = {1'b0, p} - {{(POS_BITS + 1 - CFG_BITS){1'b0}}, win};
      dec      = diff - (POS_BITS + 1)'(1);
      neg      = '0 - diff;
      r.lo_pos = !diff[POS_BITS] && (diff != '0);
      // ceil of a positive n is floor(n - 1) + 1, of a non-positive n is -floor(-n)
      r.lo_div = r.lo_pos ? dec[POS_BITS-1:0] : neg[POS_BITS-1:0];
      r.p_zero = (p == '0);
      r.hi_div = r.p_zero ? '0 : p - POS_BITS'(1);
      return r;
   endfunction

   always_comb begin
      push_cmd              = '0;
      push_ok               = 1'b0;
      push_cmd.window_index = req_data.window_index;
      push_cmd.read_id      = req_data.read_id;
      push_cmd.pos[0]       = prep_pos(req_data.start_pos, window_size);
      push_cmd.pos[1]       = prep_pos(req_data.end_pos, window_size);
      unique case (req_data.action)
         ACT_MARK_PLUS: begin
            push_cmd.kind   = CMD_MARK;
            push_cmd.strand = 1'b0;
            push_ok         = 1'b1;
         end
         ACT_MARK_MINUS: begin
            push_cmd.kind   = CMD_MARK;
            push_cmd.strand = 1'b1;
            push_ok         = 1'b1;
         end
         ACT_TEST: begin
            push_cmd.kind   = CMD_TEST;
            push_cmd.strand = req_data.strand;
            push_ok         = 1'b1;
         end
         ACT_NONE: begin
            push_ok = 1'b0;
         end
      endcase
   end

   assign busy = (count_ff == Q_CNT_BITS'(QUEUE_DEPTH)) || hold;
   assign push = start && !busy && push_ok;

   assign wr_ptr_in = push  ? wr_ptr_ff + Q_PTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? rd_ptr_ff + Q_PTR_BITS'(1) : rd_ptr_ff;
   assign count_in  = count_ff + Q_CNT_BITS'(push) - Q_CNT_BITS'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = q_mem_ff[rd_ptr_ff];

endmodule

>>> design/wkrf_div.sv
// wkrf_div: restoring divider, one quotient bit per cycle
// depends on wkrf_pkg
module wkrf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          div_start,
   input  logic [wkrf_pkg::POS_BITS-1:0] dividend,
   input  logic [wkrf_pkg::CFG_BITS-1:0] divisor,
   output logic                          div_done,
   output logic [wkrf_pkg::POS_BITS-1:0] quotient
);
   import wkrf_pkg::*;

   localparam int CNT_BITS = $clog2(POS_BITS);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CFG_BITS-1:0] rem_ff, rem_in;
   logic [POS_BITS-1:0] quo_ff, quo_in;
   logic [CFG_BITS:0]   rem_sh;
   logic [CFG_BITS:0]   rem_sub;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[POS_BITS-1]};
      rem_sub = rem_sh - {1'b0, divisor};
      ge      = (rem_sh >= {1'b0, divisor});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_start) begin
         run_in = 1'b1;
         cnt_in = CNT_BITS'(POS_BITS - 1);
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = ge ? rem_sub[CFG_BITS-1:0] : rem_sh[CFG_BITS-1:0];
         quo_in = {quo_ff[POS_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/wkrf_back.sv
// wkrf_back: keep maps, clearing pass, window range math and map scan
// depends on wkrf_pkg and wkrf_div
module wkrf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  wkrf_pkg::q_port_type          q_head,
   output logic                          q_pop,
   output logic                          clearing,
   input  logic [wkrf_pkg::CFG_BITS-1:0] step_size,
   output logic                          rsp_strobe,
   output wkrf_pkg::rsp_type             rsp_data
);
   import wkrf_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LO_GO,
      S_LO_WAIT,
      S_HI_GO,
      S_HI_WAIT,
      S_SCAN
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic                 pos_ff, pos_in;
   logic [LO_BITS-1:0]   lo_ff, lo_in;
   logic [WIN_BITS-1:0]  hi_ff, hi_in;
   logic                 hit_ff, hit_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic                 issue_done_ff, issue_done_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [ROW_BITS-1:0]  chk_row_ff, chk_row_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [WORD_BITS-1:0] plus_map_mem  [ROWS];
   logic [WORD_BITS-1:0] minus_map_mem [ROWS];
   logic [WORD_BITS-1:0] plus_rd_ff;
   logic [WORD_BITS-1:0] minus_rd_ff;
   logic                 mem_clear;
   logic                 mem_set_plus;
   logic                 mem_set_minus;
   logic [ROW_BITS-1:0]  mem_wr_row;
   logic [BIT_BITS-1:0]  mem_set_bit;
   logic [ROW_BITS-1:0]  mem_rd_row;

   logic                 div_start;
   logic [POS_BITS-1:0]  div_dividend;
   logic                 div_done;
   logic [POS_BITS-1:0]  div_quotient;

   pos_prep_type         cur_pos;
   logic [LO_BITS-1:0]   lo_calc;
   logic [WIN_BITS-1:0]  hi_calc;
   logic [WORD_BITS-1:0] scan_word;
   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] hi_mask;
   logic                 pos_done;

   wkrf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (div_dividend),
      .divisor   (step_size),
      .div_done  (div_done),
      .quotient  (div_quotient)
   );

   assign cur_pos = cmd_ff.pos[pos_ff];

   // clipped window bounds from the quotient
   always_comb begin
      if (cur_pos.lo_pos) begin
         if (div_quotient >= POS_BITS'(NUM_WINDOWS - 2)) begin
            lo_calc = LO_BITS'(NUM_WINDOWS);   // past the map, range empty
         end else begin
            lo_calc = LO_BITS'(div_quotient[WIN_BITS-1:0]) + LO_BITS'(2);
         end
      end else begin
         lo_calc = (div_quotient == '0) ? LO_BITS'(1) : '0;
      end
      if (cur_pos.p_zero) begin
         hi_calc = '0;
      end else if (div_quotient >= POS_BITS'(NUM_WINDOWS - 1)) begin
         hi_calc = '1;
      end else begin
         hi_calc = div_quotient[WIN_BITS-1:0] + WIN_BITS'(1);
      end
   end

   // masks for the partial first and last rows
   always_comb begin
      scan_word = cmd_ff.strand ? minus_rd_ff : plus_rd_ff;
      lo_mask   = '1;
      hi_mask   = '1;
      if (chk_row_ff == lo_ff[WIN_BITS-1:BIT_BITS]) begin
         lo_mask = {WORD_BITS{1'b1}} << lo_ff[BIT_BITS-1:0];
      end
      if (chk_row_ff == hi_ff[WIN_BITS-1:BIT_BITS]) begin
         hi_mask = {WORD_BITS{1'b1}} >> (BIT_BITS'(WORD_BITS - 1) - hi_ff[BIT_BITS-1:0]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      hit_in        = hit_ff;
      row_in        = row_ff;
      issue_done_in = issue_done_ff;
      chk_valid_in  = 1'b0;
      chk_row_in    = chk_row_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      mem_clear     = 1'b0;
      mem_set_plus  = 1'b0;
      mem_set_minus = 1'b0;
      mem_wr_row    = row_ff;
      mem_set_bit   = q_head.cmd.window_index[BIT_BITS-1:0];
      mem_rd_row    = row_ff;
      div_start     = 1'b0;
      div_dividend  = cur_pos.lo_div;
      pos_done      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_clear = 1'b1;
            row_in    = row_ff + ROW_BITS'(1);
            if (row_ff == {ROW_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.cmd.kind == CMD_MARK) begin
                  mem_wr_row    = q_head.cmd.window_index[WIN_BITS-1:BIT_BITS];
                  mem_set_plus  = !q_head.cmd.strand;
                  mem_set_minus = q_head.cmd.strand;
               end else begin
                  cmd_in   = q_head.cmd;
                  pos_in   = 1'b0;
                  hit_in   = 1'b0;
                  state_in = S_LO_GO;
               end
            end
         end
         S_LO_GO: begin
            div_start = 1'b1;
            state_in  = S_LO_WAIT;
         end
         S_LO_WAIT: begin
            if (div_done) begin
               lo_in    = lo_calc;
               state_in = S_HI_GO;
            end
         end
         S_HI_GO: begin
            div_start    = 1'b1;
            div_dividend = cur_pos.hi_div;
            state_in     = S_HI_WAIT;
         end
         S_HI_WAIT: begin
            if (div_done) begin
               hi_in = hi_calc;
               if (lo_ff <= {1'b0, hi_calc}) begin
                  row_in        = lo_ff[WIN_BITS-1:BIT_BITS];
                  issue_done_in = 1'b0;
                  state_in      = S_SCAN;
               end else begin
                  pos_done = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (!issue_done_ff) begin
               chk_valid_in = 1'b1;
               chk_row_in   = row_ff;
               row_in       = row_ff + ROW_BITS'(1);
               if (row_ff == hi_ff[WIN_BITS-1:BIT_BITS]) begin
                  issue_done_in = 1'b1;
               end
            end
            if (chk_valid_ff) begin
               hit_in = hit_ff || (|(scan_word & lo_mask & hi_mask));
            end
            if (issue_done_ff && !chk_valid_ff) begin
               pos_done = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end position only matters when the start found nothing
      if (pos_done) begin
         if (hit_ff || pos_ff) begin
            rsp_strobe_in        = 1'b1;
            rsp_data_in.read_tag = cmd_ff.read_id;
            rsp_data_in.keep     = hit_ff;
            state_in             = S_IDLE;
         end else begin
            pos_in   = 1'b1;
            state_in = S_LO_GO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         row_ff        <= '0;
         chk_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         chk_valid_ff  <= chk_valid_in;
         issue_done_ff <= issue_done_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      hit_ff      <= hit_in;
      chk_row_ff  <= chk_row_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_clear) begin
         plus_map_mem[mem_wr_row] <= '0;
      end else if (mem_set_plus) begin
         plus_map_mem[mem_wr_row][mem_set_bit] <= 1'b1;
      end
      plus_rd_ff <= plus_map_mem[mem_rd_row];
   end

   always_ff @(posedge clock) begin
      if (mem_clear) begin
         minus_map_mem[mem_wr_row] <= '0;
      end else if (mem_set_minus) begin
         minus_map_mem[mem_wr_row][mem_set_bit] <= 1'b1;
      end
      minus_rd_ff <= minus_map_mem[mem_rd_row];
   end

   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (chk_row_ff >= lo_ff[WIN_BITS-1:BIT_BITS]) &&
                       (chk_row_ff <= hi_ff[WIN_BITS-1:BIT_BITS]))
      else $error("scan row outside the window range");

   a_div_done_awaited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_LO_WAIT) || (state_ff == S_HI_WAIT))
      else $error("divider finished with nobody waiting");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("two responses in a row");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !q_pop && !rsp_strobe_ff)
      else $error("activity during the clearing pass");

endmodule

>>> verif/window_keep_read_filter_test.sv
// window_keep_read_filter_test: self-checking bench for the kept-window read filter
// depends on wkrf_pkg and window_keep_read_filter; drives marks, tests and csr writes,
// predicts every keep verdict from its own copy of the two strand bitmaps
`timescale 1ns / 1ps

module window_keep_read_filter_test;
   import wkrf_pkg::*;

   // drain time after the last response: one slow read of both positions, with margin
   localparam int     DRAIN_CYCLES = 2500;
   // cycles without any request or response taken before the run is declared hung
   localparam int     HANG_LIMIT   = 40000;
   localparam longint POS_MAX      = 64'd2147483647;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   req_type                 req_data = '0;
   logic                    busy;
   logic                    rsp_strobe;
   rsp_type                 rsp_data;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]     csr_wdata = '0;

   // mirror of the block: kept-window maps per strand and the two registers
   bit                      plus_kept [NUM_WINDOWS];
   bit                      minus_kept [NUM_WINDOWS];
   logic [CFG_BITS-1:0]     win_cfg = 16'd1;
   logic [CFG_BITS-1:0]     step_cfg = 16'd1;

   req_type                 request_q [$];      // requests not yet offered to the block
   rsp_type                 keep_verdict_q [$]; // predicted verdicts, oldest first
   int                      plus_marks [$];     // windows marked so far, to aim reads at
   int                      minus_marks [$];
   int                      mismatch_count = 0;
   int                      quiet_cycles = 0;
   int                      idle_left = 0;
   int                      burst_left = 0;
   rsp_type                 oldest_verdict;

   window_keep_read_filter dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   // does one position of a read fall in any kept window of the strand's map
   function automatic bit window_hit(input logic strand, input logic [POS_BITS-1:0] pos);
      longint p, w, s, n, first_win, last_win, k;
      p = pos;
      w = win_cfg;
      s = step_cfg;
      // zero step acts as one
      if (s == 0) s = 1;
      // first window: 1 + ceil((p - window) / step), quotient truncates toward zero
      n = p - w;
      first_win = n / s;
      if (n % s != 0 && n > 0) first_win++;
      first_win++;
      // last window: 1 + floor((p - 1) / step)
      n = p - 1;
      last_win = n / s;
      if (n % s != 0 && n < 0) last_win--;
      last_win++;
      // clip to the map; a range left empty finds nothing
      if (first_win < 0) first_win = 0;
      if (last_win > NUM_WINDOWS - 1) last_win = NUM_WINDOWS - 1;
      for (k = first_win; k <= last_win; k++) begin
         if (strand ? minus_kept[k] : plus_kept[k]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // update the mirror for one taken request, queue its verdict if it has one
   task automatic apply_request(input req_type r);
      rsp_type verdict;
      case (r.action)
         ACT_MARK_PLUS: begin
            plus_kept[r.window_index] = 1'b1;
         end
         ACT_MARK_MINUS: begin
            minus_kept[r.window_index] = 1'b1;
         end
         ACT_TEST: begin
            verdict.read_tag = r.read_id;
            // end position is only looked at when the start found nothing
            verdict.keep = window_hit(r.strand, r.start_pos) ||
                           window_hit(r.strand, r.end_pos);
            keep_verdict_q = {keep_verdict_q, verdict};
         end
         default: begin
            // unused action: taken and dropped, no response
         end
      endcase
   endtask

   // position aimed at a chosen window under the current window and step
   function automatic logic [POS_BITS-1:0] pick_position(input logic minus);
      longint k, p, s;
      int     sel;
      s = step_cfg;
      if (s == 0) s = 1;
      sel = $urandom_range(0, 9);
      // a few positions anywhere in the 31-bit range, a few near zero
      if (sel == 6) return POS_BITS'($urandom());
      if (sel == 7) return POS_BITS'($urandom_range(0, 1023));
      if (sel < 4 && minus && minus_marks.size() > 0)
         k = minus_marks[$urandom_range(0, minus_marks.size() - 1)];
      else if (sel < 4 && !minus && plus_marks.size() > 0)
         k = plus_marks[$urandom_range(0, plus_marks.size() - 1)];
      else if (sel < 8)
         k = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(65408, 65535);
      else
         k = $urandom_range(0, 65535);
      // window k spans (k-1)*step+1 .. (k-1)*step+window; the offset also lands
      // one base before and one past it
      p = (k - 1) * s + $urandom_range(0, win_cfg + 1);
      if (p < 0) p = 0;
      if (p > POS_MAX) p = POS_MAX;
      return p[POS_BITS-1:0];
   endfunction

   task automatic queue_request(input logic [1:0] action, input logic [15:0] widx,
                                input logic strand, input logic [POS_BITS-1:0] spos,
                                input logic [POS_BITS-1:0] epos,
                                input logic [ID_BITS-1:0] id);
      req_type r;
      r.action       = action;
      r.window_index = widx;
      r.strand       = strand;
      r.start_pos    = spos;
      r.end_pos      = epos;
      r.read_id      = id;
      request_q = {request_q, r};
   endtask

   task automatic queue_random_request();
      req_type r;
      int      pick;
      // unused fields carry random bits too
      r.window_index = 16'($urandom());
      r.strand       = 1'($urandom());
      r.start_pos    = POS_BITS'($urandom());
      r.end_pos      = POS_BITS'($urandom());
      r.read_id      = $urandom();
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
         r.action = pick[0] ? ACT_MARK_MINUS : ACT_MARK_PLUS;
         // most marks go to a hot zone at both ends of the map
         if (pick < 5)
            r.window_index = 16'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                                      : $urandom_range(65408, 65535));
         if (r.action == ACT_MARK_MINUS) minus_marks = {minus_marks, int'(r.window_index)};
         else plus_marks = {plus_marks, int'(r.window_index)};
      end else if (pick < 19) begin
         r.action    = ACT_TEST;
         r.start_pos = pick_position(r.strand);
         r.end_pos   = pick_position(r.strand);
      end else begin
         r.action = ACT_NONE;
      end
      request_q = {request_q, r};
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_WINDOW_SIZE) win_cfg = value;
      else step_cfg = value;
   endtask

   // wait until every request is taken and answered, then let trailing marks retire
   task automatic drain_block();
      while (request_q.size() != 0 || start || keep_verdict_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CFG_BITS-1:0] win, input logic [CFG_BITS-1:0] step,
                            input int count);
      write_csr(CSR_WINDOW_SIZE, win);
      write_csr(CSR_STEP_SIZE, step);
      @(negedge clock);
      repeat (count) queue_random_request();
      drain_block();
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         req_data   <= '0;
         idle_left  = 0;
         burst_left = 0;
      end else begin
         if (start && !busy) begin
            apply_request(req_data);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               // gaps from none to longer than a divider pass
               case ($urandom_range(0, 3))
                  0:       idle_left = 0;
                  1:       idle_left = $urandom_range(1, 4);
                  2:       idle_left = $urandom_range(5, 40);
                  default: idle_left = $urandom_range(41, 160);
               endcase
            end
         end
         // a request held against busy stays put
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (request_q.size() != 0) begin
               start    <= 1'b1;
               req_data <= request_q.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response monitor: every strobe is matched against the oldest verdict
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (keep_verdict_q.size() == 0) begin
            report_mismatch($sformatf("response tag %h keep %b with none expected",
                                      rsp_data.read_tag, rsp_data.keep));
         end else begin
            oldest_verdict = keep_verdict_q.pop_front();
            if (rsp_data.read_tag !== oldest_verdict.read_tag ||
                rsp_data.keep !== oldest_verdict.keep)
               report_mismatch($sformatf("got tag %h keep %b, expected tag %h keep %b",
                                         rsp_data.read_tag, rsp_data.keep,
                                         oldest_verdict.read_tag, oldest_verdict.keep));
         end
      end
   end

   // hang watchdog, covers the clearing pass and the drain pauses
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("window_keep_read_filter verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset values (window 1, step 1): position p lies in window p only
      queue_request(ACT_TEST, 16'd0, 1'b0, 31'd0, 31'd0, 32'd0);          // empty maps
      queue_request(ACT_NONE, 16'hFFFF, 1'b1, '1, '1, '1);                  // unused action
      queue_request(ACT_MARK_PLUS, 16'd0, 1'b1, '0, '0, 32'd1);
      queue_request(ACT_MARK_PLUS, 16'hFFFF, 1'b0, '1, '1, 32'd2);
      queue_request(ACT_MARK_MINUS, 16'd1, 1'b0, 31'd5, 31'd5, 32'd3);
      queue_request(ACT_MARK_MINUS, 16'h8000, 1'b0, '0, '0, 32'd4);
      // position zero reaches window zero
      queue_request(ACT_TEST, 16'd0, 1'b0, 31'd0, 31'd0, 32'hFFFF_FFFF);
      queue_request(ACT_TEST, 16'd0, 1'b1, 31'd0, 31'd0, 32'hA5A5_5A5A);
      // last window of the map
      queue_request(ACT_TEST, 16'hFFFF, 1'b0, 31'd65535, 31'd100, 32'h5A5A_A5A5);
      // ranges above the map clip to empty
      queue_request(ACT_TEST, 16'd0, 1'b0, '1, '1, 32'd10);
      queue_request(ACT_TEST, 16'd0, 1'b0, 31'd65536, 31'd65536, 32'd11);
      // start misses, end hits
      queue_request(ACT_TEST, 16'd0, 1'b1, 31'd5, 31'd1, 32'd12);
      // neighbors of a kept window miss, the kept window itself hits
      queue_request(ACT_TEST, 16'd0, 1'b1, 31'd32767, 31'd32769, 32'd13);
      queue_request(ACT_TEST, 16'd0, 1'b1, 31'd32768, 31'd7, 32'd14);
      // unused action must not mark window 2
      queue_request(ACT_NONE, 16'd2, 1'b0, 31'd2, 31'd2, 32'd15);
      queue_request(ACT_TEST, 16'd2, 1'b0, 31'd2, 31'd2, 32'd16);
      queue_request(ACT_MARK_MINUS, 16'hFFFF, 1'b1, '1, '1, 32'd17);
      queue_request(ACT_TEST, 16'd0, 1'b1, '1, 31'd65535, 32'd18);
      queue_request(ACT_TEST, 16'd0, 1'b0, 31'd1, 31'd65534, 32'd19);
      drain_block();

      // zero window and zero step, then the extremes; a huge window with step one
      // scans the whole map per position, so it gets only a few requests
      run_phase(16'd0, 16'd0, 40);
      run_phase(16'd65535, 16'd65535, 40);
      run_phase(16'd65535, 16'd1, 12);
      run_phase(16'd1, 16'd65535, 40);
      run_phase(16'd16, 16'd4, 60);
      repeat (6) run_phase(CFG_BITS'($urandom_range(0, 300)),
                           CFG_BITS'($urandom_range(0, 300)), 50);

      if (mismatch_count == 0 && keep_verdict_q.size() == 0) begin
         $display("window_keep_read_filter verification clean");
      end else begin
         $display("window_keep_read_filter verification failed");
      end
      $finish;
   end

endmodule
